// ===== rtl/core/bfr_pkg.sv =====
// ---------------------------------------------------------------------------
// Bitstream field reader package
// Shared constants, operation codes and the decode plan structure.
// ---------------------------------------------------------------------------
package bfr_pkg;

	localparam int STREAM_BYTES = 4096;
	localparam int ADDR_W       = $clog2(STREAM_BYTES);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int POS_W        = CNT_W + 3;

	localparam logic [3:0] OP_RESTART = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_READ    = 4'd2;
	localparam logic [3:0] OP_PEEK    = 4'd3;
	localparam logic [3:0] OP_SU      = 4'd4;
	localparam logic [3:0] OP_NS      = 4'd5;
	localparam logic [3:0] OP_LE      = 4'd6;
	localparam logic [3:0] OP_UE      = 4'd7;
	localparam logic [3:0] OP_SKIP    = 4'd8;

	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_SU    = 3'd1;
	localparam logic [2:0] MODE_NS    = 3'd2;
	localparam logic [2:0] MODE_LE    = 3'd3;
	localparam logic [2:0] MODE_UE    = 3'd4;

	typedef struct packed {
		logic             run;
		logic             ok;
		logic [2:0]       mode;
		logic [5:0]       nbits;
		logic [16:0]      ns_m;
		logic             ns_ext_ok;
		logic             commit;
		logic [POS_W-1:0] left;
	} plan_t;

endpackage

// ===== rtl/core/bfr_if.sv =====
// ---------------------------------------------------------------------------
// Bitstream field reader channels
// Valid/ready channels for commands and for results.
// ---------------------------------------------------------------------------
interface bfr_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [15:0] argument;
	logic [7:0]  data_byte;

	modport source (output valid, opcode, argument, data_byte, input ready);
	modport sink (input valid, opcode, argument, data_byte, output ready);
endinterface

interface bfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        ok;

	modport source (output valid, value, ok, input ready);
	modport sink (input valid, value, ok, output ready);
endinterface

// ===== rtl/core/bfr_stream_mem.sv =====
// ---------------------------------------------------------------------------
// Stream byte memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bfr_stream_mem (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [bfr_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic                      rd_en,
	input  logic [bfr_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                rd_data
);
	import bfr_pkg::*;

	logic [7:0] mem [STREAM_BYTES];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered and valid in the cycle after the request.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/core/bfr_plan.sv =====
// ---------------------------------------------------------------------------
// Command decode
// Checks argument and data availability and sets up the bit engine.
// ---------------------------------------------------------------------------
module bfr_plan (
	input  logic [3:0]                opcode,
	input  logic [15:0]               argument,
	input  logic [bfr_pkg::POS_W-1:0] pos,
	input  logic [bfr_pkg::CNT_W-1:0] loaded,
	output bfr_pkg::plan_t            plan
);
	import bfr_pkg::*;

	logic [POS_W-1:0] left;
	logic [31:0]      arg32;
	logic [31:0]      left32;
	logic [4:0]       ns_w;

	// Bits remaining in the loaded stream.
	assign left   = {loaded, 3'b000} - pos;
	assign arg32  = 32'(argument);
	assign left32 = 32'(left);

	// Alphabet width: index of the top set bit plus one, or one for zero.
	always_comb begin
		ns_w = 5'd1;
		for (int i = 0; i < 16; i++) begin
			if (argument[i]) begin
				ns_w = 5'(i + 1);
			end
		end
	end

	always_comb begin
		plan           = '0;
		plan.left      = left;
		plan.commit    = 1'b1;
		plan.ns_m      = (17'd1 << ns_w) - 17'(argument);
		plan.ns_ext_ok = 32'(ns_w) <= left32;
		unique case (opcode)
			OP_READ, OP_PEEK: begin
				plan.run    = (arg32 <= 32'd32) && (arg32 <= left32);
				plan.mode   = MODE_PLAIN;
				plan.nbits  = argument[5:0];
				plan.commit = (opcode == OP_READ);
			end
			OP_SU: begin
				plan.run   = (arg32 >= 32'd1) && (arg32 <= 32'd16) && (arg32 <= left32);
				plan.mode  = MODE_SU;
				plan.nbits = argument[5:0];
			end
			OP_NS: begin
				plan.run   = 32'(ns_w - 5'd1) <= left32;
				plan.mode  = MODE_NS;
				plan.nbits = 6'(ns_w - 5'd1);
			end
			OP_LE: begin
				plan.run   = (arg32 <= 32'd4) && ((arg32 << 3) <= left32);
				plan.mode  = MODE_LE;
				plan.nbits = {argument[2:0], 3'b000};
			end
			OP_UE: begin
				plan.run  = (left != '0);
				plan.mode = MODE_UE;
			end
			OP_RESTART: begin
				plan.ok = 1'b1;
			end
			OP_LOAD: begin
				plan.ok = (loaded != CNT_W'(STREAM_BYTES));
			end
			OP_SKIP: begin
				plan.ok = arg32 <= left32;
			end
			default: begin
				plan.ok = 1'b0;
			end
		endcase
	end
endmodule

// ===== rtl/core/bitstream_field_reader.sv =====
// ---------------------------------------------------------------------------
// Bitstream field reader
// Loads stream bytes into memory and parses MSB-first header fields.
// ---------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   opcode, argument, data_byte
//  rsp      out  valid/ready   value, ok
//
// Restart, load, skip and failed checks go from the command transfer straight
// to the done state. A field read fetches each byte it touches from memory,
// shifts its bits in one at a time, then passes the finish step and the done
// state. An ns code that needs its extra bit passes the finish step twice.
// The single memory read port and the bit-serial shift set the pace. Reset
// clears the position, the byte count and the handshake state. A finished
// command waits until the output register is free, and the next command is
// taken while that result waits for its transfer.
// ---------------------------------------------------------------------------
module bitstream_field_reader (
	input  logic      clk,
	input  logic      arst_n,
	bfr_req_if.sink   req,
	bfr_rsp_if.source rsp
);
	import bfr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_BITS  = 3'd2;
	localparam logic [2:0] S_FINAL = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] loaded_q;
	logic [POS_W-1:0] cur_q;
	logic [POS_W-1:0] left_q;
	logic [31:0]      acc_q;
	logic [5:0]       rem_q;
	logic [5:0]       lz_q;
	logic             suffix_q;
	logic             ns_ext_q;
	logic [2:0]       mode_q;
	logic [15:0]      arg_q;
	logic [16:0]      ns_m_q;
	logic             ns_ext_ok_q;
	logic             commit_q;
	logic [31:0]      res_value_q;
	logic             res_ok_q;
	logic             out_valid_q;
	logic [31:0]      out_value_q;
	logic             out_ok_q;

	plan_t            plan;
	logic             accept;
	logic             mem_wr;
	logic             mem_rd;
	logic [7:0]       rd_data;
	logic             bit_in;
	logic [POS_W-1:0] cur_nx;
	logic [5:0]       lz_nx;
	logic [31:0]      su_mask;
	logic [31:0]      le_val;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;
	assign rsp.ok    = out_ok_q;

	bfr_plan u_plan (
		.opcode   (req.opcode),
		.argument (req.argument),
		.pos      (pos_q),
		.loaded   (loaded_q),
		.plan     (plan)
	);

	assign mem_wr = accept && (req.opcode == OP_LOAD) && plan.ok;
	assign mem_rd = (state_q == S_FETCH);

	bfr_stream_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (loaded_q[ADDR_W-1:0]),
		.wr_data (req.data_byte),
		.rd_en   (mem_rd),
		.rd_addr (cur_q[ADDR_W+2:3]),
		.rd_data (rd_data)
	);

	// Current bit from the fetched byte and helpers for the bit engine and the finish step.
	assign bit_in  = rd_data[3'd7 - cur_q[2:0]];
	assign cur_nx  = cur_q + POS_W'(1);
	assign lz_nx   = lz_q + 6'd1;
	assign su_mask = (32'd1 << arg_q[4:0]) - 32'd1;

	always_comb begin
		unique case (arg_q[2:0])
			3'd1:    le_val = {24'd0, acc_q[7:0]};
			3'd2:    le_val = {16'd0, acc_q[7:0], acc_q[15:8]};
			3'd3:    le_val = {8'd0, acc_q[7:0], acc_q[15:8], acc_q[23:16]};
			3'd4:    le_val = {acc_q[7:0], acc_q[15:8], acc_q[23:16], acc_q[31:24]};
			default: le_val = 32'd0;
		endcase
	end

	// Command sequencer and bit engine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= '0;
			loaded_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q       <= pos_q;
						left_q      <= plan.left;
						acc_q       <= '0;
						lz_q        <= '0;
						suffix_q    <= 1'b0;
						ns_ext_q    <= 1'b0;
						mode_q      <= plan.mode;
						arg_q       <= req.argument;
						rem_q       <= plan.nbits;
						ns_m_q      <= plan.ns_m;
						ns_ext_ok_q <= plan.ns_ext_ok;
						commit_q    <= plan.commit;
						res_value_q <= '0;
						res_ok_q    <= plan.ok;
						if (plan.run) begin
							if (plan.mode != MODE_UE && plan.nbits == '0) begin
								state_q <= S_FINAL;
							end else begin
								state_q <= S_FETCH;
							end
						end else begin
							state_q <= S_DONE;
							if (req.opcode == OP_RESTART) begin
								pos_q    <= '0;
								loaded_q <= '0;
							end else if (mem_wr) begin
								loaded_q <= loaded_q + CNT_W'(1);
							end else if (req.opcode == OP_SKIP && plan.ok) begin
								pos_q <= pos_q + POS_W'(req.argument);
							end
						end
					end
				end
				S_FETCH: begin
					state_q <= S_BITS;
				end
				S_BITS: begin
					cur_q <= cur_nx;
					if (mode_q == MODE_UE && !suffix_q) begin
						// Leading-zero count for exp-Golomb.
						if (bit_in) begin
							if (32'({lz_q, 1'b1}) <= 32'(left_q)) begin
								if (lz_q == '0) begin
									state_q <= S_FINAL;
								end else begin
									suffix_q <= 1'b1;
									rem_q    <= lz_q;
									state_q  <= (cur_nx[2:0] == 3'd0) ? S_FETCH : S_BITS;
								end
							end else begin
								res_ok_q <= 1'b0;
								state_q  <= S_DONE;
							end
						end else if (lz_nx == 6'd32 || 32'(lz_nx) >= 32'(left_q)) begin
							res_ok_q <= 1'b0;
							state_q  <= S_DONE;
						end else begin
							lz_q    <= lz_nx;
							state_q <= (cur_nx[2:0] == 3'd0) ? S_FETCH : S_BITS;
						end
					end else begin
						// Shift one field bit in.
						acc_q <= {acc_q[30:0], bit_in};
						rem_q <= rem_q - 6'd1;
						if (rem_q == 6'd1) begin
							state_q <= S_FINAL;
						end else begin
							state_q <= (cur_nx[2:0] == 3'd0) ? S_FETCH : S_BITS;
						end
					end
				end
				S_FINAL: begin
					if (mode_q == MODE_NS && !ns_ext_q && 32'(ns_m_q) <= acc_q) begin
						// The code needs one more bit; it fails when none is left.
						res_ok_q <= 1'b0;
						if (ns_ext_ok_q) begin
							ns_ext_q <= 1'b1;
							rem_q    <= 6'd1;
							state_q  <= (cur_q[2:0] == 3'd0) ? S_FETCH : S_BITS;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q  <= S_DONE;
						res_ok_q <= 1'b1;
						if (commit_q) begin
							pos_q <= cur_q;
						end
						unique case (mode_q)
							MODE_SU: begin
								if ((acc_q & (su_mask ^ (su_mask >> 1))) != '0) begin
									res_value_q <= acc_q | ~su_mask;
								end else begin
									res_value_q <= acc_q;
								end
							end
							MODE_LE: begin
								res_value_q <= le_val;
							end
							MODE_UE: begin
								res_value_q <= ((32'd1 << lz_q[4:0]) - 32'd1) + acc_q;
							end
							MODE_NS: begin
								if (ns_ext_q) begin
									res_value_q <= acc_q - 32'(ns_m_q);
								end else begin
									res_value_q <= acc_q;
								end
							end
							default: begin
								res_value_q <= acc_q;
							end
						endcase
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: a result transfer frees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_value_q <= res_ok_q ? res_value_q : 32'd0;
			out_ok_q    <= res_ok_q;
		end
	end
endmodule

// ===== test/tb_bitstream_field_reader.sv =====
// ---------------------------------------------------------------------------
// Bitstream field reader testbench
// Drives load and field commands with random gaps, predicts each result from
// a behavioral copy of the stream state and checks the results in order.
// ---------------------------------------------------------------------------
module tb_bitstream_field_reader;
	import bfr_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1600;

	typedef struct {
		logic [31:0] value;
		logic        ok;
	} field_result_t;

	typedef struct {
		logic [3:0]  opcode;
		logic [15:0] argument;
		logic [7:0]  data_byte;
		int          repeats;
		bit          typed;
		logic [31:0] value;
		logic        ok;
	} command_row_t;

	logic clk;
	logic arst_n;

	bfr_req_if req_ch ();
	bfr_rsp_if rsp_ch ();

	bitstream_field_reader i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Behavioral copy of the stream state
	logic [7:0]  stream_mem [STREAM_BYTES];
	int unsigned byte_count;
	int unsigned read_pos;

	field_result_t pending_fields[$];
	int unsigned   quiet_cycles;
	int unsigned   error_count;
	bit            sender_done;

	function automatic int unsigned stream_bit(int unsigned pos);
		int unsigned idx;
		idx = pos >> 3;
		if (idx >= byte_count)
			return 0;
		return (stream_mem[idx] >> (7 - (pos & 7))) & 1;
	endfunction

	function automatic int unsigned stream_bits(int unsigned pos, int unsigned n);
		int unsigned v;
		v = 0;
		for (int unsigned i = 0; i < n; i++)
			v = (v << 1) | stream_bit(pos + i);
		return v;
	endfunction

	// Applies one command to the state and returns the field it produces.
	function automatic field_result_t decode_field(logic [3:0] op, logic [15:0] a,
			logic [7:0] b);
		field_result_t r;
		int unsigned left, arg, w, m, v, lz, sign;
		bit found;
		arg = 32'(a);
		left = (read_pos <= byte_count * 8) ? byte_count * 8 - read_pos : 0;
		r.value = 0;
		r.ok = 0;
		case (op)
			OP_RESTART: begin
				byte_count = 0;
				read_pos = 0;
				r.ok = 1;
			end
			OP_LOAD: begin
				if (byte_count < STREAM_BYTES) begin
					stream_mem[byte_count] = b;
					byte_count++;
					r.ok = 1;
				end
			end
			OP_READ, OP_PEEK: begin
				if (arg <= 32 && arg <= left) begin
					r.value = stream_bits(read_pos, arg);
					if (op == OP_READ)
						read_pos += arg;
					r.ok = 1;
				end
			end
			OP_SU: begin
				if (arg >= 1 && arg <= 16 && arg <= left) begin
					sign = 1 << (arg - 1);
					v = stream_bits(read_pos, arg);
					if (v & sign)
						v |= ~((sign << 1) - 1);
					r.value = v;
					read_pos += arg;
					r.ok = 1;
				end
			end
			OP_NS: begin
				w = 0;
				while (w < 17 && (1 << w) <= arg)
					w++;
				if (w == 0)
					w = 1;
				m = (1 << w) - arg;
				if (w - 1 <= left) begin
					v = stream_bits(read_pos, w - 1);
					if (v < m) begin
						r.value = v;
						read_pos += w - 1;
						r.ok = 1;
					end else if (w <= left) begin
						r.value = (v << 1) - m + stream_bit(read_pos + w - 1);
						read_pos += w;
						r.ok = 1;
					end
				end
			end
			OP_LE: begin
				if (arg <= 4 && arg * 8 <= left) begin
					v = 0;
					for (int unsigned i = 0; i < arg; i++)
						v |= stream_bits(read_pos + i * 8, 8) << (i * 8);
					r.value = v;
					read_pos += arg * 8;
					r.ok = 1;
				end
			end
			OP_UE: begin
				lz = 0;
				found = 0;
				while (lz < 32 && lz < left && !found) begin
					if (stream_bit(read_pos + lz))
						found = 1;
					else
						lz++;
				end
				if (found && 2 * lz + 1 <= left) begin
					r.value = ((1 << lz) - 1) + stream_bits(read_pos + lz + 1, lz);
					read_pos += 2 * lz + 1;
					r.ok = 1;
				end
			end
			OP_SKIP: begin
				if (arg <= left) begin
					read_pos += arg;
					r.ok = 1;
				end
			end
			default: begin
			end
		endcase
		if (!r.ok)
			r.value = 0;
		return r;
	endfunction

	// Clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
	end

	// Issues one command after a random gap and records its expected field.
	task automatic send_command(logic [3:0] op, logic [15:0] a, logic [7:0] b,
			bit typed, logic [31:0] typed_value, logic typed_ok, int max_gap);
		int gap;
		field_result_t r;
		gap = $urandom_range(0, max_gap);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1;
		req_ch.opcode <= op;
		req_ch.argument <= a;
		req_ch.data_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		r = decode_field(op, a, b);
		if (typed) begin
			r.value = typed_value;
			r.ok = typed_ok;
		end
		pending_fields.push_back(r);
	endtask

	// Directed commands; typed expectations only where obvious.
	command_row_t directed_rows[] = '{
		'{OP_READ,    16'd8,     8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_UE,      16'd0,     8'h00, 1, 1, 32'h0,        1'b0},
		'{4'hF,       16'hFFFF,  8'hFF, 1, 1, 32'h0,        1'b0},
		'{OP_LOAD,    16'd0,     8'h80, 1, 1, 32'h0,        1'b1},
		'{OP_LOAD,    16'd0,     8'hFF, 1, 1, 32'h0,        1'b1},
		'{OP_LOAD,    16'd0,     8'h00, 4, 1, 32'h0,        1'b1},
		'{OP_LOAD,    16'd0,     8'h01, 1, 1, 32'h0,        1'b1},
		'{OP_READ,    16'd0,     8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_PEEK,    16'd33,    8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_PEEK,    16'd32,    8'h00, 1, 1, 32'h80FF0000, 1'b1},
		'{OP_READ,    16'd1,     8'h00, 1, 1, 32'h1,        1'b1},
		'{OP_SU,      16'd17,    8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_SU,      16'd0,     8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_SU,      16'd7,     8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_SU,      16'd4,     8'h00, 1, 1, 32'hFFFFFFFF, 1'b1},
		'{OP_NS,      16'd0,     8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_NS,      16'd5,     8'h00, 1, 0, 32'h0,        1'b0},
		'{OP_LE,      16'd5,     8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_LE,      16'd0,     8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_LE,      16'd2,     8'h00, 1, 0, 32'h0,        1'b0},
		'{OP_UE,      16'd0,     8'h00, 1, 0, 32'h0,        1'b0},
		'{OP_SKIP,    16'hFFFF,  8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_RESTART, 16'd0,     8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_LOAD,    16'd0,     8'h00, 40, 1, 32'h0,       1'b1},
		'{OP_UE,      16'd0,     8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_SKIP,    16'd312,   8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_READ,    16'd8,     8'h00, 1, 1, 32'h0,        1'b1},
		'{OP_READ,    16'd1,     8'h00, 1, 1, 32'h0,        1'b0},
		'{OP_RESTART, 16'd0,     8'h00, 1, 1, 32'h0,        1'b1}
	};

	// Stimulus: directed table, then random sessions of loads and reads
	initial begin
		logic [3:0]  op;
		logic [15:0] a;
		logic [7:0]  b;
		int          issued;
		int          nbytes;
		int          nreads;
		int          max_gap;
		bit          paused;
		req_ch.valid = 0;
		req_ch.opcode = OP_RESTART;
		req_ch.argument = 0;
		req_ch.data_byte = 0;
		byte_count = 0;
		read_pos = 0;
		error_count = 0;
		sender_done = 0;
		@(posedge arst_n);
		foreach (directed_rows[i]) begin
			for (int k = 0; k < directed_rows[i].repeats; k++) begin
				send_command(directed_rows[i].opcode, directed_rows[i].argument,
					directed_rows[i].data_byte, directed_rows[i].typed,
					directed_rows[i].value, directed_rows[i].ok,
					(directed_rows[i].repeats > 1) ? 0 : 8);
			end
		end
		issued = 0;
		paused = 0;
		while (issued < RANDOM_ITEMS) begin
			// Some sessions run back to back with no gaps at all.
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
			if (!paused && issued > RANDOM_ITEMS / 2) begin
				@(negedge clk);
				req_ch.valid <= 0;
				while (pending_fields.size() != 0)
					@(posedge clk);
				paused = 1;
			end
			send_command(OP_RESTART, 16'd0, 8'($urandom), 0, 0, 0, max_gap);
			nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 12);
			for (int i = 0; i < nbytes; i++) begin
				case ($urandom_range(0, 3))
					0: b = 8'h00;
					1: b = 8'h01 << $urandom_range(0, 7);
					default: b = 8'($urandom);
				endcase
				send_command(OP_LOAD, 16'($urandom), b, 0, 0, 0, max_gap);
			end
			issued += nbytes + 1;
			nreads = $urandom_range(2, 16);
			for (int i = 0; i < nreads; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					op = 4'($urandom_range(0, 15));
					a = 16'($urandom);
				end else begin
					op = 4'($urandom_range(OP_READ, OP_SKIP));
					case (op)
						OP_READ, OP_PEEK: a = 16'($urandom_range(0, 34));
						OP_SU:  a = 16'($urandom_range(0, 17));
						OP_NS:  a = ($urandom_range(0, 7) == 0) ? 16'($urandom)
							: 16'($urandom_range(0, 300));
						OP_LE:  a = 16'($urandom_range(0, 5));
						OP_UE:  a = 16'($urandom);
						default: a = 16'($urandom_range(0, 40));
					endcase
				end
				send_command(op, a, 8'($urandom), 0, 0, 0, max_gap);
			end
			issued += nreads;
		end
		@(negedge clk);
		req_ch.valid <= 0;
		sender_done = 1;
	end

	// Result side: random stalls and in-order comparison
	initial begin
		int stall;
		field_result_t want;
		rsp_ch.ready = 0;
		forever begin
			stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_fields.size() == 0) begin
				$display("%0t: unexpected transfer value=%h ok=%b", $time,
					rsp_ch.value, rsp_ch.ok);
				error_count++;
			end else begin
				want = pending_fields.pop_front();
				if (rsp_ch.value !== want.value) begin
					$display("%0t: value expected %h actual %h", $time,
						want.value, rsp_ch.value);
					error_count++;
				end
				if (rsp_ch.ok !== want.ok) begin
					$display("%0t: ok expected %b actual %b", $time,
						want.ok, rsp_ch.ok);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Drain and final verdict
	initial begin
		wait (sender_done);
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
